[rtl/spbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbp_pkg: shared types and constants
// Sequencer states and configuration register indexes of the spectrum peak
// and band power block.
// ----------------------------------------------------------------------------
package spbp_pkg;

  localparam int BIN_W  = 32;
  localparam int CFG_W  = 11;
  localparam int FREQ_W = 16;
  localparam int OUT_PEAKS = 3;

  localparam logic CFG_FREQ_MAX = 1'b0;
  localparam logic CFG_NUM_BINS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIN,
    ST_EDGE,
    ST_FIN,
    ST_P1_GO,
    ST_P1_WAIT,
    ST_P2_GO,
    ST_P2_WAIT,
    ST_SC_RD,
    ST_SC_ACC,
    ST_CV_MUL,
    ST_CV_GO,
    ST_CV_WAIT,
    ST_EMIT
  } state_t;

endpackage

[rtl/spbp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbp_div: shared restoring divider
// One quotient bit per cycle from start to done.
// ----------------------------------------------------------------------------
module spbp_div import spbp_pkg::*; #(
  parameter int DW = 50
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    quo_r;
  logic [DW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, dvs_r}) : DW'(trial);
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

[rtl/spbp_peaks.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbp_peaks: sorted table of the largest distinct peak amplitudes
// One insert per cycle; an equal amplitude only moves its index.
// ----------------------------------------------------------------------------
module spbp_peaks import spbp_pkg::*; #(
  parameter int TOP_PEAKS = 3,
  parameter int IW = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             add,
  input  logic [BIN_W-1:0] add_ampl,
  input  logic [IW-1:0]    add_idx,
  output logic [BIN_W-1:0] top_ampl [OUT_PEAKS],
  output logic [IW-1:0]    top_idx [OUT_PEAKS],
  output logic             full
);

  localparam int SLOTS = TOP_PEAKS + 1;
  localparam int PW = $clog2(SLOTS + 1);

  logic [BIN_W-1:0] ampl_r [SLOTS];
  logic [IW-1:0]    idx_r [SLOTS];
  logic [SLOTS-1:0] vld_r;
  logic [SLOTS-1:0] same;
  logic [PW-1:0]    pos;
  logic             pos_hit;

  always_comb begin
    pos = PW'(SLOTS);
    pos_hit = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      same[s] = vld_r[s] && (ampl_r[s] == add_ampl);
      if (!pos_hit && (!vld_r[s] || add_ampl > ampl_r[s])) begin
        pos = PW'(s);
        pos_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        ampl_r[s] <= '0;
        idx_r[s]  <= '0;
      end
    end else if (add) begin
      if (|same) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (same[s]) idx_r[s] <= add_idx;
        end
      end else if (pos_hit) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (PW'(s) == pos) begin
            ampl_r[s] <= add_ampl;
            idx_r[s]  <= add_idx;
            vld_r[s]  <= 1'b1;
          end
        end
        // shift lower entries down one slot
        for (int s = 1; s < SLOTS; s++) begin
          if (PW'(s) > pos) begin
            ampl_r[s] <= ampl_r[s-1];
            idx_r[s]  <= idx_r[s-1];
            vld_r[s]  <= vld_r[s-1];
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < OUT_PEAKS; k++) begin
      top_ampl[k] = '0;
      top_idx[k]  = '0;
      if (k < TOP_PEAKS) begin
        top_ampl[k] = ampl_r[k % SLOTS];
        top_idx[k]  = idx_r[k % SLOTS];
      end
    end
  end

  assign full = vld_r[TOP_PEAKS];

endmodule

[rtl/spectrum_peak_and_band_power_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_peak_and_band_power_top: spectral peaks and band power
// Stores one spectrum of bins, tracks peaks and zone power, and after the
// last bin derives zone percents, the 60 percent frequency and peak freqs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_bin_value
//  out_    | output    | out_valid/out_stall | peak, zone and level fields
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Each bin passes idle (accept) and update; the last bin also edge and finish.
//  After the last bin, if any power was summed: two percent divisions on the
//  shared divider and a scan of the stored bins for the 60 percent level;
//  then four frequency conversions, each a multiply and a division; the
//  result is registered in the emit state, which waits while a result stalls.
//  Reset is synchronous; the store holds no reset value and needs no sweep.
//  A stalled result holds in the output register; the next spectrum may start.
// ----------------------------------------------------------------------------
module spectrum_peak_and_band_power_top import spbp_pkg::*; #(
  parameter int MAX_BINS  = 1024,
  parameter int TOP_PEAKS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BIN_W-1:0]  in_bin_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [FREQ_W-1:0] out_peak1_freq,
  output logic [BIN_W-1:0]  out_peak1_ampl,
  output logic [FREQ_W-1:0] out_peak2_freq,
  output logic [BIN_W-1:0]  out_peak2_ampl,
  output logic [FREQ_W-1:0] out_peak3_freq,
  output logic [BIN_W-1:0]  out_peak3_ampl,
  output logic [FREQ_W-1:0] out_level60_freq,
  output logic [6:0]        out_zone1_percent,
  output logic [6:0]        out_zone2_percent,
  output logic signed [7:0] out_zone3_percent,
  output logic              out_peaks_found,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IW = $clog2(MAX_BINS);
  localparam int NW = $clog2(MAX_BINS + 1);
  localparam int FW = IW + CFG_W;
  localparam int CW = FW + 4;
  localparam int SW = BIN_W + IW;
  localparam int DW = SW + 8;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] freq_max_r, num_bins_r;
  logic [NW-1:0]    n;
  logic [BIN_W-1:0] mem [MAX_BINS];
  logic [BIN_W-1:0] rd_r;
  logic [IW-1:0]    idx_r, j_r, lvl_j_r;
  logic [BIN_W-1:0] cur_r, prev0_r, prev1_r;
  logic [FW-1:0]    fprod_r, fm_r;
  logic [SW-1:0]    tot_r, z1_r, z2_r, s_r, s_nxt;
  logic             edge_r, found_r;
  logic [1:0]       conv_k_r;
  logic [6:0]       p1_r, p2_r;
  logic [FREQ_W-1:0] cv_f_r [4];

  logic             last, in_zone0, in_z1, in_z2, over60, scan_in;
  logic [CW-1:0]    six_n, fprod_c;
  logic [DW-1:0]    ten_s, six_t;

  logic             div_start, div_busy, div_done;
  logic [DW-1:0]    div_a, div_b, div_q;
  logic [FREQ_W-1:0] div_sat;

  logic             pk_add, pk_clear, pk_full;
  logic [BIN_W-1:0] pk_ampl;
  logic [IW-1:0]    pk_idx;
  logic [BIN_W-1:0] top_ampl [OUT_PEAKS];
  logic [IW-1:0]    top_idx [OUT_PEAKS];
  logic [IW-1:0]    cv_idx;
  logic             emit_go, accept;

  // effective bin count, clamped to 2..MAX_BINS
  always_comb begin
    if (32'(num_bins_r) > MAX_BINS) n = NW'(MAX_BINS);
    else if (num_bins_r < 11'd2) n = NW'(2);
    else n = NW'(num_bins_r);
  end

  assign last     = 32'(idx_r) >= 32'(n) - 32'd1;
  assign six_n    = (CW'(n) << 2) + (CW'(n) << 1);
  assign fprod_c  = CW'(fprod_r);
  assign in_zone0 = fprod_c <= six_n;
  assign in_z1    = ((fprod_c << 2) + fprod_c) <= CW'(n);
  assign in_z2    = fprod_c <= (CW'(n) << 1);
  assign scan_in  = CW'(fm_r) <= six_n;
  assign s_nxt    = s_r + SW'(rd_r);
  assign ten_s    = (DW'(s_nxt) << 3) + (DW'(s_nxt) << 1);
  assign six_t    = (DW'(tot_r) << 2) + (DW'(tot_r) << 1);
  assign over60   = ten_s > six_t;
  assign div_sat  = (div_q > DW'(16'hFFFF)) ? 16'hFFFF : div_q[FREQ_W-1:0];
  assign accept   = in_valid && !in_stall;
  // take register writes only between bins
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    case (conv_k_r)
      2'd0:    cv_idx = lvl_j_r;
      2'd1:    cv_idx = top_idx[0];
      2'd2:    cv_idx = top_idx[1];
      default: cv_idx = top_idx[2];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_BIN;
      ST_BIN:     state_nxt = last ? ST_EDGE : ST_IDLE;
      ST_EDGE:    state_nxt = ST_FIN;
      ST_FIN:     state_nxt = (tot_r == '0) ? ST_CV_MUL : ST_P1_GO;
      ST_P1_GO:   state_nxt = ST_P1_WAIT;
      ST_P1_WAIT: if (div_done) state_nxt = ST_P2_GO;
      ST_P2_GO:   state_nxt = ST_P2_WAIT;
      ST_P2_WAIT: if (div_done) state_nxt = ST_SC_RD;
      ST_SC_RD:   state_nxt = ST_SC_ACC;
      ST_SC_ACC: begin
        if ((scan_in && over60) || j_r == idx_r) state_nxt = ST_CV_MUL;
        else state_nxt = ST_SC_RD;
      end
      ST_CV_MUL:  state_nxt = ST_CV_GO;
      ST_CV_GO:   state_nxt = ST_CV_WAIT;
      ST_CV_WAIT: if (div_done) state_nxt = (conv_k_r == 2'd3) ? ST_EMIT : ST_CV_MUL;
      ST_EMIT:    if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    pk_add    = 1'b0;
    pk_ampl   = prev0_r;
    pk_idx    = idx_r - 1'b1;
    emit_go   = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_BIN: begin
        if (idx_r == IW'(1)) pk_add = prev0_r > cur_r;
        else if (idx_r > IW'(1)) pk_add = prev0_r > prev1_r && prev0_r > cur_r;
      end
      ST_EDGE: begin
        pk_add  = edge_r;
        pk_ampl = cur_r;
        pk_idx  = idx_r;
      end
      ST_P1_GO: begin
        div_start = 1'b1;
        div_a = (DW'(z1_r) << 7) + (DW'(z1_r) << 6) + (DW'(z1_r) << 3) + DW'(tot_r);
        div_b = DW'(tot_r) << 1;
      end
      ST_P2_GO: begin
        div_start = 1'b1;
        div_a = (DW'(z2_r) << 7) + (DW'(z2_r) << 6) + (DW'(z2_r) << 3) + DW'(tot_r);
        div_b = DW'(tot_r) << 1;
      end
      ST_CV_GO: begin
        div_start = 1'b1;
        div_a = DW'(fm_r) << 8;
        div_b = DW'(n);
      end
      ST_EMIT: emit_go = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign pk_clear = emit_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      freq_max_r <= 11'd25;
      num_bins_r <= 11'd512;
      out_valid  <= 1'b0;
      idx_r      <= '0;
      prev0_r    <= '0;
      prev1_r    <= '0;
      tot_r      <= '0;
      z1_r       <= '0;
      z2_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FREQ_MAX: freq_max_r <= cfg_data;
          CFG_NUM_BINS: num_bins_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_BIN) begin
        if (in_zone0) tot_r <= tot_r + SW'(cur_r);
        if (in_z1) z1_r <= z1_r + SW'(cur_r);
        else if (in_z2) z2_r <= z2_r + SW'(cur_r);
        prev1_r <= prev0_r;
        prev0_r <= cur_r;
        if (!last) idx_r <= idx_r + 1'b1;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
        idx_r     <= '0;
        prev0_r   <= '0;
        prev1_r   <= '0;
        tot_r     <= '0;
        z1_r      <= '0;
        z2_r      <= '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // bin store and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_BIN) mem[idx_r] <= cur_r;
    if (state_r == ST_SC_RD) rd_r <= mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r   <= in_bin_value;
      fprod_r <= FW'(idx_r) * FW'(freq_max_r);
    end
    case (state_r)
      ST_BIN: edge_r <= idx_r >= IW'(1) && cur_r > prev0_r;
      ST_FIN: begin
        p1_r     <= '0;
        p2_r     <= '0;
        found_r  <= 1'b0;
        j_r      <= '0;
        s_r      <= '0;
        lvl_j_r  <= '0;
        conv_k_r <= '0;
      end
      ST_P1_WAIT: if (div_done) p1_r <= div_q[6:0];
      ST_P2_WAIT: if (div_done) p2_r <= div_q[6:0];
      ST_SC_RD: fm_r <= FW'(j_r) * FW'(freq_max_r);
      ST_SC_ACC: begin
        if (scan_in) begin
          s_r <= s_nxt;
          if (over60) begin
            found_r <= 1'b1;
            lvl_j_r <= j_r;
          end
        end
        j_r <= j_r + 1'b1;
      end
      ST_CV_MUL: fm_r <= FW'(cv_idx) * FW'(freq_max_r);
      ST_CV_WAIT: begin
        if (div_done) begin
          cv_f_r[conv_k_r] <= div_sat;
          conv_k_r <= conv_k_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (emit_go) begin
      out_peak1_freq    <= pk_full ? cv_f_r[1] : '0;
      out_peak1_ampl    <= pk_full ? top_ampl[0] : '0;
      out_peak2_freq    <= pk_full ? cv_f_r[2] : '0;
      out_peak2_ampl    <= pk_full ? top_ampl[1] : '0;
      out_peak3_freq    <= pk_full ? cv_f_r[3] : '0;
      out_peak3_ampl    <= pk_full ? top_ampl[2] : '0;
      out_level60_freq  <= found_r ? cv_f_r[0] : '0;
      out_zone1_percent <= p1_r;
      out_zone2_percent <= p2_r;
      out_zone3_percent <= 8'sd100 - signed'({1'b0, p1_r}) - signed'({1'b0, p2_r});
      out_peaks_found   <= pk_full;
    end
  end

  spbp_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  spbp_peaks #(.TOP_PEAKS(TOP_PEAKS), .IW(IW)) u_peaks (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (pk_clear),
    .add      (pk_add),
    .add_ampl (pk_ampl),
    .add_idx  (pk_idx),
    .top_ampl (top_ampl),
    .top_idx  (top_idx),
    .full     (pk_full)
  );

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_accept_bin: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_BIN)
    else $error("accepted bin not processed");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (idx_r == '0 && tot_r == '0 && out_valid))
    else $error("set not cleared after result");

  a_wait_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_P1_WAIT || state_r == ST_P2_WAIT || state_r == ST_CV_WAIT))
    else $error("divider result outside a wait state");

endmodule

[bench/tb_spectrum_peak_and_band_power_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_peak_and_band_power_top: self-checking bench for the block
// Streams spectra of magnitude bins through the block under several freq_max
// and num_bins settings. An in-bench predictor computes peaks, zone percents
// and the 60 percent frequency for every spectrum. Each result beat is
// compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_spectrum_peak_and_band_power_top import spbp_pkg::*;;

  localparam int MAX_BINS = 1024;
  localparam int SLOTS    = 4;     // three reported peaks plus one to detect more
  localparam int IDLE_LAT = 16;    // cycles for a bin with no result to settle

  typedef struct packed {
    logic [15:0] p1_freq;
    logic [31:0] p1_ampl;
    logic [15:0] p2_freq;
    logic [31:0] p2_ampl;
    logic [15:0] p3_freq;
    logic [31:0] p3_ampl;
    logic [15:0] lvl60;
    logic [6:0]  zone1;
    logic [6:0]  zone2;
    logic [7:0]  zone3;
    logic        found;
  } spec_result_t;

  typedef enum logic { ROW_CFG, ROW_BIN } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic         reg_idx;
    logic [31:0]  value;
    bit           fixed;   // use the typed-in result instead of the predictor
    spec_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_bin_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_peak1_freq, out_peak2_freq, out_peak3_freq, out_level60_freq;
  logic [31:0] out_peak1_ampl, out_peak2_ampl, out_peak3_ampl;
  logic [6:0]  out_zone1_percent, out_zone2_percent;
  logic signed [7:0] out_zone3_percent;
  logic        out_peaks_found;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_FREQ_MAX;
  logic [10:0] cfg_data = '0;

  spectrum_peak_and_band_power_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_bin_value(in_bin_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_peak1_freq(out_peak1_freq), .out_peak1_ampl(out_peak1_ampl),
    .out_peak2_freq(out_peak2_freq), .out_peak2_ampl(out_peak2_ampl),
    .out_peak3_freq(out_peak3_freq), .out_peak3_ampl(out_peak3_ampl),
    .out_level60_freq(out_level60_freq),
    .out_zone1_percent(out_zone1_percent), .out_zone2_percent(out_zone2_percent),
    .out_zone3_percent(out_zone3_percent), .out_peaks_found(out_peaks_found),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------- spectrum predictor ----------------
  logic [10:0] mdl_freq_max = 11'd25;
  logic [10:0] mdl_num_bins = 11'd512;
  logic [31:0] bin_mem [MAX_BINS];
  int unsigned bin_pos;
  logic [31:0] prev0, prev1;
  logic [31:0] pk_ampl [SLOTS];
  int unsigned pk_idx  [SLOTS];
  bit          pk_vld  [SLOTS];
  longint unsigned pwr_total, pwr_z1, pwr_z2;

  spec_result_t expected_results[$];
  int fails = 0;
  int results_seen = 0;
  int bins_sent = 0;

  function automatic void clear_spectrum();
    bin_pos = 0;
    prev0 = '0;
    prev1 = '0;
    for (int s = 0; s < SLOTS; s++) begin
      pk_ampl[s] = '0;
      pk_idx[s] = 0;
      pk_vld[s] = 1'b0;
    end
    pwr_total = 0;
    pwr_z1 = 0;
    pwr_z2 = 0;
  endfunction

  function automatic void rank_peak(logic [31:0] ampl, int unsigned idx);
    int pos;
    pos = SLOTS;
    for (int s = 0; s < SLOTS; s++) begin
      if (pk_vld[s] && pk_ampl[s] == ampl) begin
        pk_idx[s] = idx;   // equal amplitude: later index wins
        return;
      end
    end
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!pk_vld[s] || ampl > pk_ampl[s]) pos = s;
    end
    if (pos >= SLOTS) return;
    for (int s = SLOTS - 1; s > pos; s--) begin
      pk_ampl[s] = pk_ampl[s-1];
      pk_idx[s] = pk_idx[s-1];
      pk_vld[s] = pk_vld[s-1];
    end
    pk_ampl[pos] = ampl;
    pk_idx[pos] = idx;
    pk_vld[pos] = 1'b1;
  endfunction

  function automatic logic [15:0] bin_freq(int unsigned idx, int unsigned n);
    longint unsigned f;
    f = (longint'(idx) * mdl_freq_max * 256) / n;
    return (f > 65535) ? 16'hFFFF : f[15:0];
  endfunction

  function automatic bit spectrum_step(logic [31:0] cur, output spec_result_t r);
    int unsigned n, i;
    longint unsigned fprod, s, p1, p2;
    logic [15:0] lvl;
    bit last;
    n = (mdl_num_bins < 2) ? 2 : (mdl_num_bins > MAX_BINS) ? MAX_BINS : mdl_num_bins;
    i = bin_pos;
    fprod = longint'(i) * mdl_freq_max;
    last = (i >= n - 1);
    lvl = '0;
    r = '0;
    if (i >= MAX_BINS) i = MAX_BINS - 1;
    bin_mem[i] = cur;
    if (i == 1) begin
      if (prev0 > cur) rank_peak(prev0, 0);
    end else if (i > 1) begin
      if (prev0 > prev1 && prev0 > cur) rank_peak(prev0, i - 1);
    end
    if (last && i >= 1 && cur > prev0) rank_peak(cur, i);
    if (fprod <= 6 * longint'(n)) pwr_total += cur;
    if (5 * fprod <= longint'(n)) pwr_z1 += cur;
    else if (fprod <= 2 * longint'(n)) pwr_z2 += cur;
    prev1 = prev0;
    prev0 = cur;
    if (!last) begin
      bin_pos = i + 1;
      return 1'b0;
    end
    p1 = 0;
    p2 = 0;
    if (pwr_total != 0) begin
      p1 = (200 * pwr_z1 + pwr_total) / (2 * pwr_total);
      p2 = (200 * pwr_z2 + pwr_total) / (2 * pwr_total);
      s = 0;
      for (int unsigned j = 0; j <= i; j++) begin
        if (longint'(j) * mdl_freq_max <= 6 * longint'(n)) begin
          s += bin_mem[j];
          if (10 * s > 6 * pwr_total) begin
            lvl = bin_freq(j, n);
            break;
          end
        end
      end
    end
    if (pk_vld[SLOTS-1]) begin
      r.p1_freq = bin_freq(pk_idx[0], n);
      r.p1_ampl = pk_ampl[0];
      r.p2_freq = bin_freq(pk_idx[1], n);
      r.p2_ampl = pk_ampl[1];
      r.p3_freq = bin_freq(pk_idx[2], n);
      r.p3_ampl = pk_ampl[2];
      r.found = 1'b1;
    end
    r.lvl60 = lvl;
    r.zone1 = p1[6:0];
    r.zone2 = p2[6:0];
    r.zone3 = 8'(100 - p1 - p2);
    clear_spectrum();
    return 1'b1;
  endfunction

  // ---------------- result checking ----------------
  int recv_idle = 0;
  int hold_req = 0, hold_seen = 0, hold_cnt = 0;

  task automatic cmp_field(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", nm, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    spec_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with no pending prediction");
        fails++;
      end else begin
        e = expected_results.pop_front();
        cmp_field("peak1_freq", e.p1_freq, out_peak1_freq);
        cmp_field("peak1_ampl", e.p1_ampl, out_peak1_ampl);
        cmp_field("peak2_freq", e.p2_freq, out_peak2_freq);
        cmp_field("peak2_ampl", e.p2_ampl, out_peak2_ampl);
        cmp_field("peak3_freq", e.p3_freq, out_peak3_freq);
        cmp_field("peak3_ampl", e.p3_ampl, out_peak3_ampl);
        cmp_field("level60_freq", e.lvl60, out_level60_freq);
        cmp_field("zone1_percent", e.zone1, out_zone1_percent);
        cmp_field("zone2_percent", e.zone2, out_zone2_percent);
        cmp_field("zone3_percent", e.zone3, out_zone3_percent[7:0]);
        cmp_field("peaks_found", e.found, out_peaks_found);
      end
    end
    // long hold-off lets the block fill up and stall its input
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 3000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // ---------------- stimulus ----------------
  int send_idle = 0;
  logic [31:0] last_bin = '0;

  task automatic send_bin(logic [31:0] v, bit fixed, spec_result_t lit);
    spec_result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bin_value <= v;
    do @(posedge clk); while (in_stall);
    bins_sent++;
    last_bin = v;
    if (spectrum_step(v, r)) expected_results.push_back(fixed ? lit : r);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_FREQ_MAX) mdl_freq_max = val;
    else mdl_num_bins = val;
  endtask

  function automatic logic [31:0] rand_bin();
    case ($urandom_range(9))
      5, 6:    return $urandom_range(0, 255);
      7:       return '0;
      8:       return 32'hFFFF_FFFF;
      9:       return last_bin;   // repeat: flat tops and equal peaks
      default: return $urandom;
    endcase
  endfunction

  task automatic send_spectrum();
    int n;
    n = (mdl_num_bins < 2) ? 2 : (mdl_num_bins > MAX_BINS) ? MAX_BINS : mdl_num_bins;
    for (int k = 0; k < n; k++) send_bin(rand_bin(), 1'b0, '0);
  endtask

  stim_row_t dir_rows[$];

  function automatic void add_cfg(logic idx, logic [31:0] val);
    dir_rows.push_back('{ROW_CFG, idx, val, 1'b0, '0});
  endfunction

  function automatic void add_bin(logic [31:0] val);
    dir_rows.push_back('{ROW_BIN, CFG_FREQ_MAX, val, 1'b0, '0});
  endfunction

  function automatic void add_bin_fixed(logic [31:0] val, spec_result_t r);
    dir_rows.push_back('{ROW_BIN, CFG_FREQ_MAX, val, 1'b1, r});
  endfunction

  initial begin
    spec_result_t zero_pwr, one_zone;
    int spectra;
    zero_pwr = '0;
    zero_pwr.zone3 = 8'd100;
    one_zone = '0;
    one_zone.zone1 = 7'd100;

    clear_spectrum();
    for (int k = 0; k < MAX_BINS; k++) bin_mem[k] = '0;

    // all-zero spectrum: no power, zone three takes all
    add_cfg(CFG_NUM_BINS, 2);
    add_bin(0);
    add_bin_fixed(0, zero_pwr);
    // full-scale bin at 0 Hz: all power in zone one, single peak only
    add_bin(32'hFFFF_FFFF);
    add_bin_fixed(0, one_zone);
    // count below range saturates to two
    add_cfg(CFG_NUM_BINS, 0);
    add_bin(3);
    add_bin(32'h0001_0000);
    // four peaks with a tie (three distinct amplitudes), edges included, at low frequency
    add_cfg(CFG_FREQ_MAX, 1);
    add_cfg(CFG_NUM_BINS, 8);
    add_bin(9); add_bin(1); add_bin(7); add_bin(2);
    add_bin(7); add_bin(1); add_bin(4); add_bin(5);
    // zero freq_max: every bin at 0 Hz; count lowered mid-spectrum
    add_cfg(CFG_FREQ_MAX, 0);
    add_cfg(CFG_NUM_BINS, 16);
    add_bin(32'h8000_0000); add_bin(5); add_bin(32'h7FFF_FFFF); add_bin(6);
    add_cfg(CFG_NUM_BINS, 3);
    add_bin(2);
    // highest freq_max, frequencies saturate
    add_cfg(CFG_FREQ_MAX, 2047);
    add_cfg(CFG_NUM_BINS, 5);
    add_bin(1); add_bin(8); add_bin(2); add_bin(9); add_bin(32'hFFFF_FFFF);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        wait_quiet();
        write_reg(dir_rows[k].reg_idx, dir_rows[k].value[10:0]);
      end else begin
        send_bin(dir_rows[k].value, dir_rows[k].fixed, dir_rows[k].res);
      end
    end

    spectra = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 20 : (ph == 1) ? 82 : 0;
      recv_idle = (ph == 0) ? 82 : (ph == 1) ? 20 : 0;
      if (ph == 2) begin
        // count above range saturates to the largest spectrum
        wait_quiet();
        write_reg(CFG_NUM_BINS, 11'd2047);
        write_reg(CFG_FREQ_MAX, 11'd1024);
        send_spectrum();
        spectra++;
      end
      for (int st = 0; st < 4; st++) begin
        int fm, sent;
        case ($urandom_range(5))
          0:       fm = 0;
          1:       fm = 2047;
          2:       fm = $urandom_range(1, 2047);
          default: fm = $urandom_range(1, 40);
        endcase
        wait_quiet();
        write_reg(CFG_FREQ_MAX, fm[10:0]);
        write_reg(CFG_NUM_BINS, 11'($urandom_range(2, 16)));
        // hold off the receiver while short spectra keep coming
        if (ph == 2 && st == 0) hold_req++;
        sent = 0;
        while (sent < 60) begin
          send_spectrum();
          spectra++;
          sent += (mdl_num_bins < 2) ? 2 : mdl_num_bins;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d bins in %0d random and directed spectra, %0d results checked",
             bins_sent, spectra + 6, results_seen);
    $display("Settings swept: freq_max 0..2047, num_bins 0..2047 with saturation");
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
